FILE: rtl/dri_pkg.sv
package dri_pkg;

    localparam int MAG_BITS  = 96;
    localparam int MAX_SCALE = 28;

    // The magnitude is carried in three 32-bit limbs whatever MAG_BITS says.
    localparam int MAG_WIDTH  = 96;
    localparam int LIMB_BITS  = 32;
    localparam int LIMBS      = MAG_WIDTH / LIMB_BITS;
    localparam int LIMB_IDX_BITS = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int SCALE_BITS = 5;
    localparam int DIGIT_BITS = 4;

    localparam int MAG_EFF = (MAG_BITS > MAG_WIDTH) ? MAG_WIDTH : MAG_BITS;
    localparam logic [MAG_WIDTH-1:0] MAG_MASK =
        {MAG_WIDTH{1'b1}} >> (MAG_WIDTH - MAG_EFF);

    // A 5-bit scale cannot ask for more than 31 digits.
    localparam int SCALE_MAX_CODE = (1 << SCALE_BITS) - 1;
    localparam int NUM_DIGITS =
        (MAX_SCALE > SCALE_MAX_CODE) ? SCALE_MAX_CODE : MAX_SCALE;
    localparam int NUM_STAGES = NUM_DIGITS * LIMBS;

    typedef enum logic [1:0] {
        ACT_FLOOR  = 2'd0,
        ACT_ROUND  = 2'd1,
        ACT_TRUNC  = 2'd2,
        ACT_NEGATE = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] mag_low;
        logic [31:0] mag_high;
        logic [4:0]  dec_scale;
        logic        negative;
    } in_item_t;

    typedef struct packed {
        logic [63:0] res_mag_low;
        logic [31:0] res_mag_high;
        logic [4:0]  res_scale;
        logic        res_negative;
    } out_item_t;

    typedef struct packed {
        logic                  valid;
        logic                  pass;
        logic [1:0]            action;
        logic [SCALE_BITS-1:0] scale;
        logic [SCALE_BITS-1:0] digits;
        logic                  neg;
        logic [MAG_WIDTH-1:0]  mag;
        logic [DIGIT_BITS-1:0] rem;
        logic [DIGIT_BITS-1:0] first;
        logic                  sticky;
    } stage_t;

endpackage

FILE: rtl/dri_div_stage.sv
module dri_div_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic [dri_pkg::SCALE_BITS-1:0] digit_idx,
    input  logic [dri_pkg::LIMB_IDX_BITS-1:0] limb_idx,
    input  dri_pkg::stage_t                stage_in,
    output dri_pkg::stage_t                stage_out
);
    import dri_pkg::*;

    localparam int X_BITS      = LIMB_BITS + DIGIT_BITS;
    localparam int RECIP_SHIFT = X_BITS + 4;
    localparam int RECIP_BITS  = RECIP_SHIFT - 3;
    localparam int PROD_BITS   = X_BITS + RECIP_BITS;
    localparam int QEST_BITS   = PROD_BITS - RECIP_SHIFT;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((128'd1 << RECIP_SHIFT) / 10);
    localparam logic [X_BITS-1:0] TEN = X_BITS'(10);

    stage_t                stage_reg;
    stage_t                stage_next;
    logic                  active;
    logic [X_BITS-1:0]     x;
    logic [PROD_BITS-1:0]  prod;
    logic [QEST_BITS-1:0]  q_est;
    logic [X_BITS-1:0]     ten_q;
    logic [X_BITS-1:0]     r_est;
    logic [LIMB_BITS-1:0]  q_limb;
    logic [DIGIT_BITS-1:0] r_digit;

    assign active = stage_in.valid && (digit_idx < stage_in.digits);
    assign x      = {stage_in.rem, stage_in.mag[limb_idx*LIMB_BITS +: LIMB_BITS]};

    // The reciprocal estimate is at most one below the true quotient.
    assign prod  = PROD_BITS'(x) * PROD_BITS'(RECIP);
    assign q_est = prod[PROD_BITS-1 -: QEST_BITS];
    assign ten_q = X_BITS'({q_est, 3'b000}) + X_BITS'({q_est, 1'b0});
    assign r_est = x - ten_q;

    always_comb begin
        if (r_est >= TEN) begin
            q_limb  = LIMB_BITS'(q_est + QEST_BITS'(1));
            r_digit = DIGIT_BITS'(r_est - TEN);
        end else begin
            q_limb  = LIMB_BITS'(q_est);
            r_digit = DIGIT_BITS'(r_est);
        end
    end

    always_comb begin
        stage_next = stage_in;
        if (active) begin
            stage_next.mag[limb_idx*LIMB_BITS +: LIMB_BITS] = q_limb;
            stage_next.rem = r_digit;
            // After the lowest limb the remainder is the digit shifted out.
            if (limb_idx == '0) begin
                stage_next.rem    = '0;
                stage_next.first  = r_digit;
                stage_next.sticky = stage_in.sticky || (r_digit != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: rtl/dri_round.sv
module dri_round (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  dri_pkg::stage_t    stage_in,
    output logic               out_valid,
    output dri_pkg::out_item_t out_item
);
    import dri_pkg::*;

    out_item_t            out_reg;
    out_item_t            out_next;
    logic                 valid_reg;
    logic                 up;
    logic [MAG_WIDTH-1:0] mag_inc;
    logic                 res_zero;

    always_comb begin
        case (stage_in.action)
            ACT_FLOOR: up = stage_in.neg && stage_in.sticky;
            ACT_ROUND: up = stage_in.first >= DIGIT_BITS'(5);
            default:   up = 1'b0;
        endcase
    end

    assign mag_inc  = (stage_in.mag + MAG_WIDTH'(up)) & MAG_MASK;
    assign res_zero = (mag_inc == '0);

    always_comb begin
        if (stage_in.pass) begin
            {out_next.res_mag_high, out_next.res_mag_low} = stage_in.mag;
            out_next.res_scale    = stage_in.scale;
            out_next.res_negative = stage_in.neg ^ (stage_in.action == ACT_NEGATE);
        end else begin
            {out_next.res_mag_high, out_next.res_mag_low} = mag_inc;
            out_next.res_scale    = '0;
            out_next.res_negative = stage_in.neg && !res_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_in.valid;
            out_reg   <= out_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = out_reg;

    a_round_scale_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        en && stage_in.valid && !stage_in.pass |=> valid_reg && out_reg.res_scale == '0)
        else $error("rounded item left with nonzero scale");

    a_exact_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        en && stage_in.valid && !stage_in.pass && !stage_in.sticky |=>
        {out_reg.res_mag_high, out_reg.res_mag_low} == $past(stage_in.mag))
        else $error("exact quotient was adjusted");

    a_zero_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        en && stage_in.valid && !stage_in.pass |=>
        !(out_reg.res_negative && out_reg.res_mag_low == '0 && out_reg.res_mag_high == '0))
        else $error("rounded zero came out negative");

endmodule

FILE: rtl/decimal_round_to_integer.sv
// Stages: NUM_STAGES dividers (28 digits of three limbs by default), then rounding.
// Throughput: one item per cycle while the output is not stalled; each stage
// divides one 32-bit limb by ten: a scale of s digits takes three stages per digit.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears every valid bit; data is not cleared.
module decimal_round_to_integer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dri_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dri_pkg::out_item_t m_data
);
    import dri_pkg::*;

    logic   en;
    stage_t stage_q [0:NUM_STAGES];
    logic [SCALE_BITS-1:0] clamp_scale;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign clamp_scale = (s_data.dec_scale > SCALE_BITS'(NUM_DIGITS)) ?
                         SCALE_BITS'(NUM_DIGITS) : s_data.dec_scale;

    always_comb begin
        stage_q[0].valid  = s_valid;
        stage_q[0].pass   = (s_data.action == ACT_NEGATE) || (s_data.dec_scale == '0);
        stage_q[0].action = s_data.action;
        stage_q[0].scale  = s_data.dec_scale;
        stage_q[0].digits = stage_q[0].pass ? '0 : clamp_scale;
        stage_q[0].neg    = s_data.negative;
        stage_q[0].mag    = {s_data.mag_high, s_data.mag_low} & MAG_MASK;
        stage_q[0].rem    = '0;
        stage_q[0].first  = '0;
        stage_q[0].sticky = 1'b0;
    end

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_div
        localparam logic [SCALE_BITS-1:0]    DIGIT = SCALE_BITS'(i / LIMBS);
        localparam logic [LIMB_IDX_BITS-1:0] LIMB  =
            LIMB_IDX_BITS'(LIMBS - 1 - (i % LIMBS));

        dri_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .digit_idx (DIGIT),
            .limb_idx  (LIMB),
            .stage_in  (stage_q[i]),
            .stage_out (stage_q[i+1])
        );
    end

    dri_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .stage_in  (stage_q[NUM_STAGES]),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dri_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int CALM_TAIL   = 100;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        in_item_t item;
        bit       drain_first;
    } stim_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    stim_t     queued_inputs[$];
    out_item_t pending_results[$];
    int        error_count = 0;
    logic      calm = 1'b0;

    int gap_left = 0;
    int gap_pct = 15;
    int items_sent = 0;
    int stall_left = 0;
    int stall_pct = 20;
    int monitor_cycles = 0;
    int quiet_cycles = 0;

    decimal_round_to_integer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Rounds one scaled decimal to an integer, or negates it, digit by digit.
    function automatic out_item_t round_decimal(in_item_t it);
        logic [95:0] mask;
        logic [95:0] mag;
        logic [3:0]  first;
        bit          sticky;
        bit          up;
        int          digits;
        out_item_t   r;
        mask = {96{1'b1}};
        if (MAG_BITS < 96) begin
            mask = mask >> (96 - MAG_BITS);
        end
        mag = {it.mag_high, it.mag_low} & mask;
        r.res_scale = it.dec_scale;
        r.res_negative = it.negative;
        first = '0;
        sticky = 1'b0;
        up = 1'b0;
        if (it.action == ACT_NEGATE) begin
            r.res_negative = ~it.negative;
        end else if (it.dec_scale != 0) begin
            digits = (it.dec_scale > MAX_SCALE) ? MAX_SCALE : int'(it.dec_scale);
            for (int i = 0; i < digits; i++) begin
                first = 4'(mag % 96'd10);
                if (first != 0) begin
                    sticky = 1'b1;
                end
                mag = mag / 96'd10;
            end
            case (it.action)
                ACT_FLOOR: begin
                    up = it.negative && sticky;
                end
                ACT_ROUND: begin
                    up = (first >= 4'd5);
                end
                default: begin
                    up = 1'b0;
                end
            endcase
            if (up) begin
                mag = mag + 96'd1;
            end
            mag = mag & mask;
            r.res_scale = '0;
            if (mag == '0) begin
                r.res_negative = 1'b0;
            end
        end
        r.res_mag_low = mag[63:0];
        r.res_mag_high = mag[95:64];
        return r;
    endfunction

    function automatic in_item_t make_item(action_t act, logic [31:0] hi, logic [63:0] lo,
                                           logic [4:0] scale, logic neg);
        in_item_t it;
        it.action = act;
        it.mag_high = hi;
        it.mag_low = lo;
        it.dec_scale = scale;
        it.negative = neg;
        return it;
    endfunction

    task automatic queue_item(in_item_t it, bit drain);
        stim_t st;
        st.item = it;
        st.drain_first = drain;
        queued_inputs.push_back(st);
    endtask

    // Driver: offers queued items, with random gaps, and holds off on a
    // marked item until the pipeline has emptied.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            calm <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(round_decimal(s_data));
            end
            calm <= (queued_inputs.size() < CALM_TAIL);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (queued_inputs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (queued_inputs[0].drain_first && pending_results.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(0, 7);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data <= queued_inputs[0].item;
                    queued_inputs.pop_front();
                    items_sent++;
                    if (items_sent % 50 == 0) begin
                        case ($urandom_range(0, 2))
                            0: gap_pct = 0;
                            1: gap_pct = 15;
                            default: gap_pct = 50;
                        endcase
                    end
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction and
    // stalls the output in random bursts.
    always @(posedge aclk) begin
        out_item_t exp_item;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    error_count++;
                end else begin
                    exp_item = pending_results.pop_front();
                    if (m_data.res_mag_low !== exp_item.res_mag_low) begin
                        $error("res_mag_low: expected %h, got %h",
                               exp_item.res_mag_low, m_data.res_mag_low);
                        error_count++;
                    end
                    if (m_data.res_mag_high !== exp_item.res_mag_high) begin
                        $error("res_mag_high: expected %h, got %h",
                               exp_item.res_mag_high, m_data.res_mag_high);
                        error_count++;
                    end
                    if (m_data.res_scale !== exp_item.res_scale) begin
                        $error("res_scale: expected %0d, got %0d",
                               exp_item.res_scale, m_data.res_scale);
                        error_count++;
                    end
                    if (m_data.res_negative !== exp_item.res_negative) begin
                        $error("res_negative: expected %b, got %b",
                               exp_item.res_negative, m_data.res_negative);
                        error_count++;
                    end
                end
            end
            monitor_cycles++;
            if (monitor_cycles % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 60;
                endcase
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [31:0] ones_hi;
        logic [63:0] ones_lo;
        logic [95:0] mag;
        logic [95:0] pow;
        logic [95:0] q;
        logic [4:0]  scale;
        int          kind;
        int          digits;

        ones_hi = '1;
        ones_lo = '1;

        // Zero, signed zero at scale zero, and negate of zero.
        queue_item(make_item(ACT_FLOOR, 32'd0, 64'd0, 5'd0, 1'b0), 1'b0);
        queue_item(make_item(ACT_ROUND, 32'd0, 64'd0, 5'd0, 1'b1), 1'b0);
        queue_item(make_item(ACT_TRUNC, 32'd0, 64'd0, 5'd0, 1'b1), 1'b0);
        queue_item(make_item(ACT_NEGATE, 32'd0, 64'd0, 5'd0, 1'b0), 1'b0);
        // Full magnitude at the extremes of the scale.
        queue_item(make_item(ACT_NEGATE, ones_hi, ones_lo, 5'd31, 1'b1), 1'b0);
        queue_item(make_item(ACT_FLOOR, ones_hi, ones_lo, 5'd28, 1'b1), 1'b0);
        queue_item(make_item(ACT_ROUND, ones_hi, ones_lo, 5'd28, 1'b0), 1'b0);
        queue_item(make_item(ACT_TRUNC, ones_hi, ones_lo, 5'd28, 1'b1), 1'b0);
        queue_item(make_item(ACT_ROUND, ones_hi, ones_lo, 5'd1, 1'b0), 1'b0);
        queue_item(make_item(ACT_FLOOR, ones_hi, ones_lo, 5'd0, 1'b1), 1'b0);
        // Halves and near halves.
        queue_item(make_item(ACT_ROUND, 32'd0, 64'd15, 5'd1, 1'b0), 1'b0);
        queue_item(make_item(ACT_ROUND, 32'd0, 64'd25, 5'd1, 1'b1), 1'b0);
        queue_item(make_item(ACT_ROUND, 32'd0, 64'd14, 5'd1, 1'b0), 1'b0);
        queue_item(make_item(ACT_ROUND, 32'd0, 64'd1450, 5'd2, 1'b0), 1'b0);
        // Floor with and without discarded digits.
        queue_item(make_item(ACT_FLOOR, 32'd0, 64'd101, 5'd2, 1'b1), 1'b0);
        queue_item(make_item(ACT_FLOOR, 32'd0, 64'd100, 5'd2, 1'b1), 1'b0);
        queue_item(make_item(ACT_FLOOR, 32'd0, 64'd101, 5'd2, 1'b0), 1'b0);
        // Results of zero must come out positive; floor of a negative fraction gives one.
        queue_item(make_item(ACT_TRUNC, 32'd0, 64'd3, 5'd1, 1'b1), 1'b0);
        queue_item(make_item(ACT_FLOOR, 32'd0, 64'd3, 5'd1, 1'b1), 1'b0);
        queue_item(make_item(ACT_ROUND, 32'd0, 64'd3, 5'd1, 1'b1), 1'b0);
        // Scales beyond the maximum are clamped for rounding; then a negate and a top-bit round.
        queue_item(make_item(ACT_ROUND, 32'd0, 64'd5, 5'd31, 1'b0), 1'b0);
        queue_item(make_item(ACT_TRUNC, ones_hi, ones_lo, 5'd30, 1'b1), 1'b0);
        queue_item(make_item(ACT_NEGATE, 32'd0, 64'd12345, 5'd7, 1'b0), 1'b0);
        queue_item(make_item(ACT_ROUND, 32'h8000_0000, 64'd0, 5'd5, 1'b1), 1'b0);

        for (int n = 0; n < 800; n++) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 9) == 0) begin
                scale = 5'($urandom_range(29, 31));
            end else begin
                scale = 5'($urandom_range(0, 28));
            end
            digits = (scale > MAX_SCALE) ? MAX_SCALE : int'(scale);
            if (kind <= 3) begin
                mag = {$urandom, $urandom, $urandom};
            end else if (kind <= 5) begin
                mag = {$urandom, $urandom, $urandom} >> $urandom_range(0, 95);
            end else if (kind <= 8) begin
                // A quotient times the power of ten plus a remainder near the
                // rounding boundary.
                pow = 96'd1;
                for (int i = 0; i < digits; i++) begin
                    pow = pow * 96'd10;
                end
                q = {$urandom, $urandom, $urandom} >> $urandom_range(0, 95);
                mag = q * pow;
                case ($urandom_range(0, 4))
                    0: mag = mag;
                    1: mag = mag + pow / 2;
                    2: mag = mag + pow / 2 - ((pow > 1) ? 96'd1 : 96'd0);
                    3: mag = mag + pow - 96'd1;
                    default: mag = mag + ({$urandom, $urandom, $urandom} % pow);
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0: mag = '1;
                    1: mag = '0;
                    default: mag = 96'd1 << $urandom_range(0, 95);
                endcase
            end
            queue_item(make_item(action_t'($urandom_range(0, 3)), mag[95:64], mag[63:0],
                                 scale, 1'($urandom_range(0, 1))),
                       (n == 0 || n == 300 || n == 600));
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_inputs.size() != 0 || s_valid || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dri_pkg.sv
rtl/dri_div_stage.sv
rtl/dri_round.sv
rtl/decimal_round_to_integer.sv
sim/testbench.sv
